>>> hw/rtl/rspd_pkg.sv
// Shared types and constants for the remote-debug serial packet deframer.
package rspd_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W       = 11;

  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_END   = 8'h23;  // '#'
  localparam logic [7:0] CHAR_ESC   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] ACK_POS    = 8'h2B;  // '+'
  localparam logic [7:0] ACK_NEG    = 8'h2D;  // '-'
  localparam logic [7:0] ACK_NONE   = 8'h00;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [7:0]       payload_byte;
    logic [POS_W-1:0] position;
    logic [7:0]       ack_byte;
  } rspd_res_t;

endpackage

>>> hw/rtl/rspd_core.sv
// Framing state machine: consumes one byte per strobe and forms its result.
module rspd_core
  import rspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_go,
  input  logic [7:0] byte_in,
  output rspd_res_t  res
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DATA = 3'd1,
    PH_ESC  = 3'd2,
    PH_HI   = 3'd3,
    PH_LO   = 3'd4
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             hi_bad_r, hi_bad_nxt;
  logic [4:0]       hex;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    u = c & 8'hDF;
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b0, 4'(c - 8'h30)};
    end else if (u >= 8'h41 && u <= 8'h46) begin
      return {1'b0, 4'(u - 8'h37)};
    end else begin
      return 5'h10;
    end
  endfunction

  assign hex = hex_value(byte_in);

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    hi_nxt     = hi_r;
    hi_bad_nxt = hi_bad_r;
    res        = '0;
    case (phase_r)
      PH_DATA: begin
        if (byte_in == CHAR_END) begin
          phase_nxt = PH_HI;
        end else if (count_r >= CNT_W'(MAX_PAYLOAD)) begin
          phase_nxt    = PH_HUNT;
          res.valid    = 1'b1;
          res.kind     = KIND_REJECT;
          res.ack_byte = ACK_NEG;
        end else if (byte_in == CHAR_ESC) begin
          phase_nxt = PH_ESC;
        end else begin
          sum_nxt          = sum_r + byte_in;
          count_nxt        = count_r + 1'b1;
          res.valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = byte_in;
          res.position     = POS_W'(count_r);
        end
      end
      PH_ESC: begin
        sum_nxt          = sum_r + CHAR_ESC + byte_in;
        count_nxt        = count_r + 1'b1;
        phase_nxt        = PH_DATA;
        res.valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = byte_in ^ ESC_XOR;
        res.position     = POS_W'(count_r);
      end
      PH_HI: begin
        hi_bad_nxt = hex[4];
        hi_nxt     = hex[3:0];
        phase_nxt  = PH_LO;
      end
      PH_LO: begin
        phase_nxt = PH_HUNT;
        res.valid = 1'b1;
        if (!hi_bad_r && !hex[4] && {hi_r, hex[3:0]} == sum_r) begin
          res.kind     = KIND_ACCEPT;
          res.position = POS_W'(count_r);
          res.ack_byte = ACK_POS;
        end else begin
          res.kind     = KIND_REJECT;
          res.ack_byte = ACK_NEG;
        end
      end
      default: begin
        if (byte_in == CHAR_START) begin
          phase_nxt  = PH_DATA;
          sum_nxt    = '0;
          count_nxt  = '0;
          hi_nxt     = '0;
          hi_bad_nxt = 1'b0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
    if (!byte_go) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      sum_r    <= '0;
      count_r  <= '0;
      hi_r     <= '0;
      hi_bad_r <= 1'b0;
    end else if (byte_go) begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      hi_r     <= hi_nxt;
      hi_bad_r <= hi_bad_nxt;
    end
  end

endmodule

>>> hw/rtl/rsp_packet_deframer.sv
// Top level of the remote-debug serial packet deframer.
//
// The input channel carries one received serial byte per beat on in_rx_byte.
// Bytes are dropped until a '$' arrives; after it every byte is payload until
// '#', with 0x7D escaping the following byte. Two hex checksum digits close
// the packet.
// The output channel carries at most one beat per input byte: a payload byte
// with its index, an accept with the packet length and ack '+', or a reject
// with ack '-'. Bytes that are dropped, the '#', escape bytes and the high
// checksum digit yield no output beat.
// A byte accepted into the input register goes through the framing logic,
// and its result is captured in the output register.
// Throughput is one byte per cycle while the receiver does not stall; the
// framing state update is a loop closed through the core's registers.
// A synchronous active-low reset empties both registers and returns the
// framer to hunting for '$'.
// When the receiver stalls with a result waiting, the result holds steady
// and the input register keeps its byte; in_stall rises only once that input
// register is also occupied.
module rsp_packet_deframer
  import rspd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [POS_W-1:0] out_position,
  output logic [7:0]       out_ack_byte
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  rspd_res_t  out_r;
  rspd_res_t  res;
  logic       advance;
  logic       byte_go;

  // The input register moves forward whenever the output register is empty
  // or its beat is being taken in this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign byte_go  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  rspd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_go (byte_go),
    .byte_in (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= res.valid;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_position     = out_r.position;
  assign out_ack_byte     = out_r.ack_byte;

endmodule
